### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, skipped while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked during reset as well
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### hdl/dtfs_pkg.sv
package dtfs_pkg;

  // Size limits of the counters
  localparam int MAX_COLUMNS = 256;
  localparam int MAX_ROWS    = 65536;

  localparam int COL_LIMIT_I = (MAX_COLUMNS - 1 > 255) ? 255 : MAX_COLUMNS - 1;
  localparam int ROW_LIMIT_I = (MAX_ROWS - 1 > 65535) ? 65535 : MAX_ROWS - 1;

  localparam logic [7:0]  COL_LIMIT = COL_LIMIT_I[7:0];
  localparam logic [15:0] ROW_LIMIT = ROW_LIMIT_I[15:0];

  // Special bytes
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] SPLIT_INIT = 8'h09;

  typedef enum logic [1:0] {
    KIND_CONTENT = 2'd0,
    KIND_DROP    = 2'd1,
    KIND_FIELD   = 2'd2,
    KIND_ROW     = 2'd3
  } kind_t;

  // Classification of one text byte
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_byte;
    logic [7:0]  column;
    logic [15:0] row;
    logic        too_many_fields;
  } token_t;

endpackage

### hdl/dtfs_text_if.sv
interface dtfs_text_if;
  import dtfs_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);

endinterface

### hdl/dtfs_token_if.sv
interface dtfs_token_if;
  import dtfs_pkg::*;

  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [7:0]  out_byte;
  logic [7:0]  column;
  logic [15:0] row;
  logic        too_many_fields;

  modport source (output valid, kind, out_byte, column, row, too_many_fields, input ready);
  modport sink (input valid, kind, out_byte, column, row, too_many_fields, output ready);

endinterface

### hdl/dtfs_core.sv
`include "assert_macros.svh"

module dtfs_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  input  logic                 fire,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output dtfs_pkg::token_t     token
);
  import dtfs_pkg::*;

  logic [7:0]  split_char;
  logic        in_quote,         in_quote_next;
  logic        quote_pending,    quote_pending_next;
  logic [7:0]  field_index,      field_index_next;
  logic [15:0] row_index,        row_index_next;
  logic [7:0]  first_row_fields, first_row_fields_next;

  logic qp_literal;
  logic quoted;

  // Separator register, kept across end of file
  always_ff @(posedge clk) begin
    if (rst) begin
      split_char <= SPLIT_INIT;
    end else if (cfg_wr_en) begin
      split_char <= cfg_wr_data;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_quote         <= 1'b0;
      quote_pending    <= 1'b0;
      field_index      <= '0;
      row_index        <= '0;
      first_row_fields <= '0;
    end else if (fire) begin
      in_quote         <= in_quote_next;
      quote_pending    <= quote_pending_next;
      field_index      <= field_index_next;
      row_index        <= row_index_next;
      first_row_fields <= first_row_fields_next;
    end
  end

  // Byte classification and next state
  always_comb begin
    qp_literal = quote_pending && (data_byte == CH_QUOTE);
    // pending quote followed by anything else closes the section
    quoted     = in_quote && !quote_pending;

    in_quote_next         = in_quote && !(quote_pending && !qp_literal);
    quote_pending_next    = 1'b0;
    field_index_next      = field_index;
    row_index_next        = row_index;
    first_row_fields_next = first_row_fields;

    token.kind            = KIND_DROP;
    token.out_byte        = '0;
    token.column          = field_index;
    token.row             = row_index;
    token.too_many_fields = (row_index != '0) && (field_index > first_row_fields);

    priority if (qp_literal) begin
      token.kind     = KIND_CONTENT;
      token.out_byte = data_byte;
    end else if (quoted) begin
      if (data_byte == CH_QUOTE) begin
        quote_pending_next = 1'b1;
      end else begin
        token.kind     = KIND_CONTENT;
        token.out_byte = data_byte;
      end
    end else if (data_byte == split_char) begin
      token.kind = KIND_FIELD;
      if (field_index < COL_LIMIT) begin
        field_index_next = field_index + 8'd1;
      end
    end else if (data_byte == CH_CR) begin
      token.kind = KIND_DROP;
    end else if (data_byte == CH_LF) begin
      token.kind = KIND_ROW;
      if (row_index == '0) begin
        first_row_fields_next = field_index;
      end
      field_index_next = '0;
      if (row_index < ROW_LIMIT) begin
        row_index_next = row_index + 16'd1;
      end
    end else if (data_byte == CH_QUOTE) begin
      in_quote_next = 1'b1;
    end else begin
      token.kind     = KIND_CONTENT;
      token.out_byte = data_byte;
    end

    // end of file clears everything but the separator
    if (last_byte) begin
      in_quote_next         = 1'b0;
      quote_pending_next    = 1'b0;
      field_index_next      = '0;
      row_index_next        = '0;
      first_row_fields_next = '0;
    end
  end

  `ASSERT_CLK(a_col_sat, clk, rst, field_index <= COL_LIMIT, "column counter past limit")
  `ASSERT_CLK(a_last_clears, clk, rst, fire && last_byte |=> field_index == '0 && row_index == '0 && !in_quote && !quote_pending, "state not cleared after last byte")
  `ASSERT_CLK(a_pending_in_quote, clk, rst, quote_pending |-> in_quote, "pending quote outside quoted section")

endmodule

### hdl/delimited_text_field_splitter_unit.sv
// Channel  Role    Beat payload
// text     sink    data_byte[7:0], last_byte
// token    source  kind[1:0], out_byte[7:0], column[7:0], row[15:0], too_many_fields
// cfg      write   cfg_wr_en, cfg_wr_data[7:0] (split character)
//
// One beat per cycle unless token stalls; each token shows in the next cycle.
// The token output register is the only pipeline stage; text.ready is high
// whenever that register is empty or being drained this cycle.
// Reset (rst, synchronous) clears parser state and sets the separator to tab.
// A stalled token holds the output register and back-pressures text.
`include "assert_macros.svh"

module delimited_text_field_splitter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  dtfs_text_if.sink   text,
  dtfs_token_if.source token
);
  import dtfs_pkg::*;

  logic   fire;
  logic   out_valid;
  token_t result;
  token_t out_reg;

  assign text.ready = !out_valid || token.ready;
  assign fire       = text.valid && text.ready;

  dtfs_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .data_byte   (text.data_byte),
    .last_byte   (text.last_byte),
    .token       (result)
  );

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (text.ready) begin
      out_valid <= text.valid;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_reg <= result;
    end
  end

  assign token.valid           = out_valid;
  assign token.kind            = out_reg.kind;
  assign token.out_byte        = out_reg.out_byte;
  assign token.column          = out_reg.column;
  assign token.row             = out_reg.row;
  assign token.too_many_fields = out_reg.too_many_fields;

  `ASSERT_CLK(a_ready_when_empty, clk, rst, !out_valid |-> text.ready, "text stalled with empty output")
  `ASSERT_CLK(a_beat_lands, clk, rst, fire |=> out_valid, "accepted beat produced no token")
  `ASSERT_CLK(a_zero_byte, clk, rst, out_valid && out_reg.kind != KIND_CONTENT |-> out_reg.out_byte == '0, "non-content token carries a byte")
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "token valid after reset")

endmodule
